// ===== sv/pdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdpc_pkg: shared types and constants of the PD position controller
// Holds the sequencer states, the register indexes and the operation codes
// of the shared multiplier.
// ----------------------------------------------------------------------------
package pdpc_pkg;

  // Yaw in Q3.13: half turn is pi, full turn is 2*pi
  localparam logic signed [17:0] HALF_TURN     = 18'sd25736;
  localparam logic signed [17:0] NEG_HALF_TURN = -18'sd25736;
  localparam logic signed [17:0] FULL_TURN     = 18'sd51472;

  // Saturation bound of a raw axis command
  localparam logic signed [50:0] RAW_CLAMP     = 51'sd1073741824;
  localparam logic signed [50:0] NEG_RAW_CLAMP = -51'sd1073741824;

  typedef enum logic [2:0] {
    REG_GAIN_X             = 3'd0,
    REG_GAIN_Y             = 3'd1,
    REG_GAIN_Z             = 3'd2,
    REG_GAIN_HEADING       = 3'd3,
    REG_LIMIT_HORIZONTAL   = 3'd4,
    REG_LIMIT_VERTICAL     = 3'd5,
    REG_LIMIT_HEADING_RATE = 3'd6,
    REG_REACH_THRESHOLDS   = 3'd7
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRODUCTS,
    S_ROOT_START,
    S_ROOT_WAIT,
    S_SCALE_MUL,
    S_DIV_START,
    S_DIV_WAIT,
    S_FINISH
  } state_t;

  // Multiplier operations, in issue order. For the PD group, bits 2:1 give
  // the axis and bit 0 selects the derivative term.
  typedef enum logic [3:0] {
    OP_KP_X    = 4'd0,
    OP_KD_X    = 4'd1,
    OP_KP_Y    = 4'd2,
    OP_KD_Y    = 4'd3,
    OP_KP_Z    = 4'd4,
    OP_KD_Z    = 4'd5,
    OP_KP_H    = 4'd6,
    OP_KD_H    = 4'd7,
    OP_SQ_X    = 4'd8,
    OP_SQ_Y    = 4'd9,
    OP_DIST_X  = 4'd10,
    OP_DIST_Y  = 4'd11,
    OP_DIST_Z  = 4'd12,
    OP_THR     = 4'd13,
    OP_SCALE_X = 4'd14,
    OP_SCALE_Y = 4'd15
  } op_t;

endpackage

// ===== sv/pdpc_mul.sv =====
// ----------------------------------------------------------------------------
// pdpc_mul: shared multiplier
// Unsigned 32 x 32 product with a registered result, one issue per cycle.
// ----------------------------------------------------------------------------
module pdpc_mul
  import pdpc_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= {32'd0, a} * {32'd0, b};
  end

endmodule

// ===== sv/pdpc_sqrt.sv =====
// ----------------------------------------------------------------------------
// pdpc_sqrt: iterative integer square root
// Floor square root of a 62-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module pdpc_sqrt
  import pdpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [61:0] value,
  output logic        done,
  output logic [30:0] root
);

  logic        busy;
  logic [61:0] rem;
  logic [61:0] res;
  logic [61:0] bitv;
  logic [61:0] trial;

  assign trial = res + bitv;
  assign root  = res[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= value;
        res  <= '0;
        bitv <= {2'b01, 60'd0};
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/pdpc_div.sv =====
// ----------------------------------------------------------------------------
// pdpc_div: iterative restoring divider
// 46-bit dividend by 31-bit divisor, one quotient bit per cycle, 16-bit
// quotient; the caller guarantees the quotient fits.
// ----------------------------------------------------------------------------
module pdpc_div
  import pdpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [45:0] dividend,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);

  logic        busy;
  logic [3:0]  cnt;
  logic [45:0] rem;
  logic [45:0] dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        rem      <= dividend;
        dsh      <= {divisor, 15'd0};
        quotient <= '0;
        cnt      <= 4'd15;
      end else if (busy) begin
        if (rem >= dsh) begin
          rem      <= rem - dsh;
          quotient <= {quotient[14:0], 1'b1};
        end else begin
          quotient <= {quotient[14:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/pd_position_controller_limited_top.sv =====
// ----------------------------------------------------------------------------
// pd_position_controller_limited_top: PD position controller, velocity limits
// Each request runs through a 31-step square root, and through two 16-step
// divides when the horizontal pair is scaled down.
// Throughput: one request at a time; the next is taken once the result
// is registered, while it still waits on the output.
// Reset: synchronous; clears stored errors and reached latch, presets registers.
// ----------------------------------------------------------------------------
module pd_position_controller_limited_top
  import pdpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, pos_z, heading, goal_x, goal_y, goal_z, goal_heading
  input  logic [223:0] s_tdata,
  // new_leg
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // cmd_x, cmd_y, cmd_z, cmd_heading
  output logic [63:0]  m_tdata,
  // reached
  output logic         m_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] n;
    n = v[32] ? 33'(-v) : 33'(v);
    return n[31:0];
  endfunction

  function automatic logic signed [31:0] sat_diff(input logic signed [31:0] g,
                                                  input logic signed [31:0] p);
    logic signed [32:0] d;
    d = {g[31], g} - {p[31], p};
    if (d[32] != d[31]) return d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    return d[31:0];
  endfunction

  function automatic logic [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) return 16'h7fff;
    if (v < -32'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic [15:0] clamp_lim(input logic signed [31:0] v,
                                            input logic [14:0] lim);
    logic signed [31:0] hi;
    hi = $signed({17'd0, lim});
    if (v > hi) return hi[15:0];
    if (v < -hi) return 16'(-hi);
    return v[15:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0] gain [4];
  logic [14:0] limit_horizontal;
  logic [14:0] limit_vertical;
  logic [14:0] limit_heading_rate;
  logic [31:0] reach_thresholds;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) gain[i] <= '0;
      limit_horizontal   <= 15'd512;
      limit_vertical     <= 15'd256;
      limit_heading_rate <= 15'd256;
      reach_thresholds   <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_GAIN_X:             gain[0] <= cfg_data;
        REG_GAIN_Y:             gain[1] <= cfg_data;
        REG_GAIN_Z:             gain[2] <= cfg_data;
        REG_GAIN_HEADING:       gain[3] <= cfg_data;
        REG_LIMIT_HORIZONTAL:   limit_horizontal   <= cfg_data[14:0];
        REG_LIMIT_VERTICAL:     limit_vertical     <= cfg_data[14:0];
        REG_LIMIT_HEADING_RATE: limit_heading_rate <= cfg_data[14:0];
        REG_REACH_THRESHOLDS:   reach_thresholds   <= cfg_data;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Request decode and error forming
  // --------------------------------------------------------------------------
  logic signed [31:0] pos_x, pos_y, pos_z, goal_x, goal_y, goal_z;
  logic signed [15:0] heading, goal_heading;
  logic               new_leg;

  assign pos_x        = s_tdata[31:0];
  assign pos_y        = s_tdata[63:32];
  assign pos_z        = s_tdata[95:64];
  assign heading      = s_tdata[111:96];
  assign goal_x       = s_tdata[143:112];
  assign goal_y       = s_tdata[175:144];
  assign goal_z       = s_tdata[207:176];
  assign goal_heading = s_tdata[223:208];
  assign new_leg      = s_tuser;

  logic signed [31:0] last_err [3];
  logic signed [15:0] last_err_heading;
  logic               reached_latch;

  logic signed [31:0] e_new [4];
  logic signed [32:0] d_new [4];
  logic signed [17:0] h_diff, h_wrap1, h_wrap2;
  logic signed [31:0] last_eff [3];
  logic signed [15:0] last_h_eff;

  always_comb begin
    h_diff = {{2{goal_heading[15]}}, goal_heading} - {{2{heading[15]}}, heading};
    // Wrap twice, though for 16-bit headings one pass already lands within a half turn
    if (h_diff > HALF_TURN)          h_wrap1 = h_diff - FULL_TURN;
    else if (h_diff < NEG_HALF_TURN) h_wrap1 = h_diff + FULL_TURN;
    else                             h_wrap1 = h_diff;
    if (h_wrap1 > HALF_TURN)          h_wrap2 = h_wrap1 - FULL_TURN;
    else if (h_wrap1 < NEG_HALF_TURN) h_wrap2 = h_wrap1 + FULL_TURN;
    else                              h_wrap2 = h_wrap1;

    e_new[0] = sat_diff(goal_x, pos_x);
    e_new[1] = sat_diff(goal_y, pos_y);
    e_new[2] = sat_diff(goal_z, pos_z);
    e_new[3] = {{16{h_wrap2[15]}}, h_wrap2[15:0]};

    for (int i = 0; i < 3; i++) begin
      last_eff[i] = new_leg ? 32'sd0 : last_err[i];
      d_new[i]    = {e_new[i][31], e_new[i]} - {last_eff[i][31], last_eff[i]};
    end
    last_h_eff = new_leg ? 16'sd0 : last_err_heading;
    d_new[3]   = {e_new[3][31], e_new[3]} - {{17{last_h_eff[15]}}, last_h_eff};
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_t state, state_next;
  op_t    op;
  logic   root_start, root_done, div_start, div_done, load_out;
  logic [30:0] root;
  logic [15:0] div_q;
  logic [30:0] norm;
  logic        lane;
  logic        accept;

  assign accept = s_tvalid && s_tready;
  assign lane   = (op == OP_SCALE_Y);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    root_start = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = S_PRODUCTS;
      end
      // Issue one multiply per cycle up to the threshold square
      S_PRODUCTS: begin
        if (op == OP_THR) state_next = S_ROOT_START;
      end
      S_ROOT_START: begin
        root_start = 1'b1;
        state_next = S_ROOT_WAIT;
      end
      // Scale the horizontal pair only when the norm is over the limit
      S_ROOT_WAIT: begin
        if (root_done) begin
          state_next = (root > {16'd0, limit_horizontal}) ? S_SCALE_MUL : S_FINISH;
        end
      end
      S_SCALE_MUL: state_next = S_DIV_START;
      S_DIV_START: begin
        div_start  = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) state_next = lane ? S_FINISH : S_SCALE_MUL;
      end
      // Hold until the output register is free
      S_FINISH: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Shared multiplier and its operand select
  // --------------------------------------------------------------------------
  logic signed [31:0] err [4];
  logic signed [32:0] dif [4];
  logic signed [31:0] cmd [4];
  logic [31:0] mul_a, mul_b;
  logic        mul_neg;
  logic [63:0] mul_p;
  logic [1:0]  op_axis;
  logic [23:0] thr;
  logic [61:0] sumsq;

  assign op_axis = op[2:1];
  assign thr     = {reach_thresholds[31:16], 8'd0};

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    unique case (op)
      OP_KP_X, OP_KP_Y, OP_KP_Z, OP_KP_H: begin
        mul_a   = {16'd0, gain[op_axis][31:16]};
        mul_b   = mag32(err[op_axis]);
        mul_neg = err[op_axis][31];
      end
      OP_KD_X, OP_KD_Y, OP_KD_Z, OP_KD_H: begin
        mul_a   = {16'd0, gain[op_axis][15:0]};
        mul_b   = mag33(dif[op_axis]);
        mul_neg = dif[op_axis][32];
      end
      OP_SQ_X: begin
        mul_a = mag32(cmd[0]);
        mul_b = mag32(cmd[0]);
      end
      OP_SQ_Y: begin
        mul_a = mag32(cmd[1]);
        mul_b = mag32(cmd[1]);
      end
      OP_DIST_X: begin
        mul_a = mag32(err[0]);
        mul_b = mag32(err[0]);
      end
      OP_DIST_Y: begin
        mul_a = mag32(err[1]);
        mul_b = mag32(err[1]);
      end
      OP_DIST_Z: begin
        mul_a = mag32(err[2]);
        mul_b = mag32(err[2]);
      end
      OP_THR: begin
        mul_a = {8'd0, thr};
        mul_b = {8'd0, thr};
      end
      OP_SCALE_X: begin
        mul_a = mag32(cmd[0]);
        mul_b = {17'd0, limit_horizontal};
      end
      OP_SCALE_Y: begin
        mul_a = mag32(cmd[1]);
        mul_b = {17'd0, limit_horizontal};
      end
    endcase
  end

  pdpc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  pdpc_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (sumsq),
    .done  (root_done),
    .root  (root)
  );

  pdpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_p[45:0]),
    .divisor  (norm),
    .done     (div_done),
    .quotient (div_q)
  );

  // --------------------------------------------------------------------------
  // Product consumption: the product of the previous issue lands here
  // --------------------------------------------------------------------------
  logic        pend_valid;
  op_t         pend_op;
  logic        pend_neg;
  logic [1:0]  pend_axis;
  logic signed [50:0] acc, sp, pd_sum, pd_shift;
  logic signed [31:0] pd_raw;
  logic [63:0] dist_sq;
  logic [47:0] thrsq;

  assign pend_axis = pend_op[2:1];

  always_comb begin
    sp       = pend_neg ? -$signed({3'b0, mul_p[47:0]}) : $signed({3'b0, mul_p[47:0]});
    pd_sum   = acc + sp;
    // Floor to Q8.8: yaw terms carry 13 fraction bits, position terms 16
    pd_shift = (pend_axis == 2'd3) ? (pd_sum >>> 13) : (pd_sum >>> 16);
    if (pd_shift > RAW_CLAMP)          pd_raw = RAW_CLAMP[31:0];
    else if (pd_shift < NEG_RAW_CLAMP) pd_raw = NEG_RAW_CLAMP[31:0];
    else                               pd_raw = pd_shift[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) pend_valid <= 1'b0;
    else     pend_valid <= (state == S_PRODUCTS) || (state == S_SCALE_MUL);
  end

  always_ff @(posedge clk) begin
    pend_op  <= op;
    pend_neg <= mul_neg;

    // Advance the operation code; an accepted request restarts it and latches its errors
    if (accept) begin
      op <= OP_KP_X;
      for (int i = 0; i < 4; i++) begin
        err[i] <= e_new[i];
        dif[i] <= d_new[i];
      end
    end else if (state == S_PRODUCTS) begin
      op <= op_t'(op + 4'd1);
    end else if (state == S_DIV_WAIT && div_done) begin
      op <= OP_SCALE_Y;
    end

    if (state == S_ROOT_WAIT && root_done) norm <= root;

    if (pend_valid) begin
      unique case (pend_op)
        OP_KP_X, OP_KP_Y, OP_KP_Z, OP_KP_H: acc <= sp;
        OP_KD_X, OP_KD_Y, OP_KD_Z, OP_KD_H: cmd[pend_axis] <= pd_raw;
        OP_SQ_X:   sumsq   <= mul_p[61:0];
        OP_SQ_Y:   sumsq   <= sumsq + mul_p[61:0];
        OP_DIST_X: dist_sq <= mul_p;
        OP_DIST_Y: dist_sq <= dist_sq + mul_p;
        OP_DIST_Z: dist_sq <= dist_sq + mul_p;
        OP_THR:    thrsq   <= mul_p[47:0];
        OP_SCALE_X, OP_SCALE_Y: ;
      endcase
    end

    // Apply the scaled magnitude with the command's own sign
    if (state == S_DIV_WAIT && div_done) begin
      cmd[lane] <= cmd[lane][31] ? -$signed({16'd0, div_q}) : $signed({16'd0, div_q});
    end
  end

  // --------------------------------------------------------------------------
  // Reach test, stored errors and the output register
  // --------------------------------------------------------------------------
  logic near_pos, near_yaw, reached_now;

  always_comb begin
    near_pos = (mag32(err[0]) < {8'd0, thr}) && (mag32(err[1]) < {8'd0, thr}) &&
               (mag32(err[2]) < {8'd0, thr}) && (dist_sq < {16'd0, thrsq});
    near_yaw = mag32(err[3]) < {16'd0, reach_thresholds[15:0]};
    reached_now = reached_latch || (near_pos && near_yaw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) last_err[i] <= '0;
      last_err_heading <= '0;
      reached_latch    <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      if (accept) begin
        for (int i = 0; i < 3; i++) last_err[i] <= e_new[i];
        last_err_heading <= e_new[3][15:0];
        if (new_leg) reached_latch <= 1'b0;
      end
      if (load_out) begin
        reached_latch <= reached_now;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {clamp_lim(cmd[3], limit_heading_rate),
                  clamp_lim(cmd[2], limit_vertical),
                  sat16(cmd[1]),
                  sat16(cmd[0])};
      m_tuser <= reached_now;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while a previous one is in progress");

  a_quotient_in_limit: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (div_q <= {1'b0, limit_horizontal}))
    else $error("scaled horizontal command exceeds its limit");

  a_scale_only_over_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_START) |-> (norm > {16'd0, limit_horizontal}))
    else $error("horizontal scaling started with the norm under the limit");

endmodule
